// File: design/tsvg_pkg.sv
// shared types, constants and fixed point helpers of the tube sweep vertex generator
package tsvg_pkg;

   localparam int MAX_RING_DEFAULT = 32;
   localparam int JOB_QUEUE_DEPTH  = 4;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic signed [15:0] UNIT_NEG_ONE = -16'sd16384;

   typedef logic signed [23:0] coord_type;
   typedef logic signed [24:0] dir_type;
   typedef logic signed [15:0] unit_type;
   typedef logic signed [33:0] wide_type;

   // one ring to be built by the back end
   typedef struct packed {
      coord_type [2:0] pt;
      dir_type   [2:0] dir;
      logic            first;
      logic [15:0]     num;
      logic            final_ring;
   } job_type;

   typedef struct packed {
      logic            start;
      wide_type [2:0]  vec;
   } unit_req_type;

   typedef struct packed {
      logic            done;
      logic            zero;
      unit_type [2:0]  u;
   } unit_rsp_type;

   // shift right by 14 with rounding half away from zero
   function automatic logic signed [39:0] rnd14(input logic signed [39:0] x);
      logic [39:0] m;
      m = x[39] ? 40'(-x) : 40'(x);
      m = (m + 40'd8192) >> 14;
      return x[39] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [39:0] x);
      if (x > 40'sd32767) return 16'sd32767;
      if (x < -40'sd32768) return -16'sd32768;
      return x[15:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [39:0] x);
      if (x > 40'sd8388607) return 24'sd8388607;
      if (x < -40'sd8388608) return -24'sd8388608;
      return x[23:0];
   endfunction

endpackage

// File: design/tsvg_queue.sv
// short job queue between the point front end and the ring back end
module tsvg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tsvg_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output tsvg_pkg::job_type pop_job,
   output logic              empty
);
   import tsvg_pkg::*;

   localparam int PW = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(JOB_QUEUE_DEPTH + 1);

   job_type        entry_ff [JOB_QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff;
   logic [PW-1:0]  rd_ff;
   logic [CW-1:0]  count_ff;

   assign full    = (count_ff == CW'(JOB_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push && !full) begin
            wr_ff <= (wr_ff == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ff <= (rd_ff == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         case ({push && !full, pop && !empty})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end
endmodule

// File: design/tsvg_front.sv
// front end: takes path points, keeps the point window and queues ring jobs
module tsvg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tsvg_pkg::coord_type req_point_x,
   input  tsvg_pkg::coord_type req_point_y,
   input  tsvg_pkg::coord_type req_point_z,
   input  logic                req_end_of_path,
   output logic                push,
   output tsvg_pkg::job_type   push_job,
   input  logic                full
);
   import tsvg_pkg::*;

   typedef enum logic [1:0] {FILL_NONE, FILL_ONE, FILL_TWO} fill_type;

   fill_type    fill_ff;
   logic [15:0] seen_ff;
   coord_type   older_ff [3];
   coord_type   newer_ff [3];
   logic        pend_ff;
   job_type     pend_job_ff;

   coord_type   p [3];
   job_type     job1;
   job_type     job2;
   logic        accept;

   assign p[0] = req_point_x;
   assign p[1] = req_point_y;
   assign p[2] = req_point_z;

   assign req_ready = !full && !pend_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      job1 = '0;
      job2 = '0;
      for (int k = 0; k < 3; k++) begin
         job1.pt[k]  = newer_ff[k];
         job1.dir[k] = 25'(p[k]) - ((fill_ff == FILL_ONE) ? 25'(newer_ff[k]) : 25'(older_ff[k]));
         job2.pt[k]  = p[k];
         job2.dir[k] = 25'(p[k]) - 25'(newer_ff[k]);
      end
      job1.first      = (fill_ff == FILL_ONE);
      job1.num        = seen_ff - 16'd1;
      job1.final_ring = 1'b0;
      job2.first      = 1'b0;
      job2.num        = seen_ff;
      job2.final_ring = 1'b1;
   end

   assign push     = (accept && fill_ff != FILL_NONE) || (pend_ff && !full);
   assign push_job = pend_ff ? pend_job_ff : job1;

   always_ff @(posedge clock) begin
      if (accept) begin
         if (fill_ff == FILL_NONE) begin
            for (int k = 0; k < 3; k++) newer_ff[k] <= p[k];
         end else if (!req_end_of_path) begin
            for (int k = 0; k < 3; k++) begin
               older_ff[k] <= newer_ff[k];
               newer_ff[k] <= p[k];
            end
         end
         pend_job_ff <= job2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= FILL_NONE;
         seen_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (pend_ff && !full) begin
            pend_ff <= 1'b0;
         end
         if (accept) begin
            if (fill_ff == FILL_NONE) begin
               fill_ff <= req_end_of_path ? FILL_NONE : FILL_ONE;
               seen_ff <= req_end_of_path ? 16'd0 : 16'd1;
            end else if (req_end_of_path) begin
               fill_ff <= FILL_NONE;
               seen_ff <= '0;
               pend_ff <= 1'b1;
            end else begin
               fill_ff <= FILL_TWO;
               seen_ff <= seen_ff + 16'd1;
            end
         end
      end
   end
endmodule

// File: design/tsvg_unit.sv
// iterative unitizer: length by square root, then per component restoring division
module tsvg_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  tsvg_pkg::unit_req_type req,
   output tsvg_pkg::unit_rsp_type rsp
);
   import tsvg_pkg::*;

   localparam int QW = 17;

   typedef enum logic [2:0] {U_IDLE, U_SQ, U_SUM, U_NORM, U_SQRT, U_LOAD, U_DIV} ust_type;

   ust_type      st_ff;
   logic [32:0]  mag_ff [3];
   logic         neg_ff [3];
   logic [63:0]  sq_ff [3];
   logic [63:0]  len_ff;
   logic [4:0]   k_ff;
   logic [63:0]  rt_ff;
   logic [63:0]  bit_ff;
   logic [31:0]  s_ff;
   logic [1:0]   ci_ff;
   logic [47:0]  rem_ff;
   logic [QW-1:0] quo_ff;
   logic [4:0]   b_ff;
   logic         done_ff;
   logic         zero_ff;
   unit_type     u_ff [3];

   logic [63:0]  len_sum;
   logic [63:0]  rt_bit;
   logic [63:0]  num64;
   logic [47:0]  dvs;
   logic         hit;
   logic [QW-1:0] quo_next;

   assign len_sum  = sq_ff[0] + sq_ff[1] + sq_ff[2];
   assign rt_bit   = rt_ff + bit_ff;
   assign num64    = ((64'(mag_ff[ci_ff]) << k_ff) << 14) + 64'(s_ff >> 1);
   assign dvs      = 48'(s_ff) << b_ff;
   assign hit      = (rem_ff >= dvs);
   assign quo_next = quo_ff | (QW'(hit) << b_ff);

   assign rsp.done = done_ff;
   assign rsp.zero = zero_ff;
   assign rsp.u[0] = u_ff[0];
   assign rsp.u[1] = u_ff[1];
   assign rsp.u[2] = u_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= ((st_ff == U_SUM) && (len_sum == '0)) ||
                    ((st_ff == U_DIV) && (b_ff == '0) && (ci_ff == 2'd2));
         case (st_ff)
            U_IDLE: begin
               if (req.start) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= req.vec[i][33];
                     mag_ff[i] <= req.vec[i][33] ? 33'(-$signed(req.vec[i]))
                                                 : 33'($signed(req.vec[i]));
                  end
                  st_ff <= U_SQ;
               end
            end
            U_SQ: begin
               for (int i = 0; i < 3; i++) sq_ff[i] <= 64'(mag_ff[i] * mag_ff[i]);
               st_ff <= U_SUM;
            end
            U_SUM: begin
               len_ff <= len_sum;
               k_ff   <= '0;
               if (len_sum == '0) begin
                  zero_ff <= 1'b1;
                  st_ff   <= U_IDLE;
               end else begin
                  st_ff <= U_NORM;
               end
            end
            U_NORM: begin
               if (len_ff < (64'd1 << 60)) begin
                  len_ff <= len_ff << 2;
                  k_ff   <= k_ff + 5'd1;
               end else begin
                  rt_ff  <= '0;
                  bit_ff <= (len_ff >= (64'd1 << 62)) ? (64'd1 << 62) : (64'd1 << 60);
                  st_ff  <= U_SQRT;
               end
            end
            U_SQRT: begin
               if (bit_ff == '0) begin
                  s_ff  <= rt_ff[31:0];
                  ci_ff <= '0;
                  st_ff <= U_LOAD;
               end else begin
                  if (len_ff >= rt_bit) begin
                     len_ff <= len_ff - rt_bit;
                     rt_ff  <= (rt_ff >> 1) + bit_ff;
                  end else begin
                     rt_ff <= rt_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            U_LOAD: begin
               rem_ff <= num64[47:0];
               quo_ff <= '0;
               b_ff   <= 5'(QW - 1);
               st_ff  <= U_DIV;
            end
            U_DIV: begin
               if (hit) rem_ff <= rem_ff - dvs;
               quo_ff <= quo_next;
               if (b_ff == '0) begin
                  u_ff[ci_ff] <= neg_ff[ci_ff] ? 16'(-$signed({1'b0, quo_next}))
                                               : 16'(quo_next);
                  if (ci_ff == 2'd2) begin
                     zero_ff <= 1'b0;
                     st_ff   <= U_IDLE;
                  end else begin
                     ci_ff <= ci_ff + 2'd1;
                     st_ff <= U_LOAD;
                  end
               end else begin
                  b_ff <= b_ff - 5'd1;
               end
            end
            default: st_ff <= U_IDLE;
         endcase
      end
   end
endmodule

// File: design/tsvg_back.sv
// back end: frame transport sequencer, trig table and vertex emission
module tsvg_back #(
   parameter int MAX_RING = tsvg_pkg::MAX_RING_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [15:0]            radius,
   input  logic [5:0]             ring_size,
   input  logic                   empty,
   input  tsvg_pkg::job_type      pop_job,
   output logic                   pop,
   output tsvg_pkg::unit_req_type unit_req,
   input  tsvg_pkg::unit_rsp_type unit_rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tsvg_pkg::coord_type    rsp_vertex_x,
   output tsvg_pkg::coord_type    rsp_vertex_y,
   output tsvg_pkg::coord_type    rsp_vertex_z,
   output tsvg_pkg::unit_type     rsp_normal_x,
   output tsvg_pkg::unit_type     rsp_normal_y,
   output tsvg_pkg::unit_type     rsp_normal_z,
   output logic [15:0]            rsp_ring_number,
   output logic [4:0]             rsp_around_index,
   output logic                   rsp_last_of_path,
   output logic                   rsp_degenerate
);
   import tsvg_pkg::*;

   localparam int RW = $clog2(MAX_RING + 1);
   localparam int JW = $clog2(MAX_RING + 1);
   localparam int IW = (MAX_RING > 1) ? $clog2(MAX_RING) : 1;

   typedef enum logic [3:0] {
      B_IDLE, B_UD, B_SEED, B_XMUL, B_XSUB, B_UT, B_RD, B_VMUL, B_VNR, B_VRAD, B_VOUT
   } bst_type;

   typedef enum logic [1:0] {X_PRE, X_TO_BIL, X_TO_LAT} xdst_type;

   // cosine and sine for every ring size, built at elaboration
   logic [31:0] rom_w [MAX_RING+1][MAX_RING];

   for (genvar N = 0; N <= MAX_RING; N++) begin : g_n
      for (genvar J = 0; J < MAX_RING; J++) begin : g_j
         if (N < 3) begin : g_pad
            assign rom_w[N][J] = '0;
         end else begin : g_val
            localparam logic [63:0] A  = (((64'(J) << 32) + 64'(N / 2)) / N) & 64'hFFFF_FFFF;
            localparam logic [63:0] QD = A >> 30;
            localparam logic [63:0] R  = A & (Q30_ONE - 64'd1);
            localparam logic [63:0] X  = (R * HALF_PI_Q30) >> 30;
            localparam logic [63:0] X2 = (X * X) >> 30;
            localparam logic [63:0] S1 = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 156;
            localparam logic [63:0] S2 = Q30_ONE - ((X2 * S1) >> 30) / 110;
            localparam logic [63:0] S3 = Q30_ONE - ((X2 * S2) >> 30) / 72;
            localparam logic [63:0] S4 = Q30_ONE - ((X2 * S3) >> 30) / 42;
            localparam logic [63:0] S5 = Q30_ONE - ((X2 * S4) >> 30) / 20;
            localparam logic [63:0] S6 = Q30_ONE - ((X2 * S5) >> 30) / 6;
            localparam logic [63:0] SN = (X * S6) >> 30;
            localparam logic [63:0] C1 = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 132;
            localparam logic [63:0] C2 = Q30_ONE - ((X2 * C1) >> 30) / 90;
            localparam logic [63:0] C3 = Q30_ONE - ((X2 * C2) >> 30) / 56;
            localparam logic [63:0] C4 = Q30_ONE - ((X2 * C3) >> 30) / 30;
            localparam logic [63:0] C5 = Q30_ONE - ((X2 * C4) >> 30) / 12;
            localparam logic [63:0] SB = ((X2 * C5) >> 30) / 2;
            localparam logic [63:0] CS = (SB >= Q30_ONE) ? 64'd0 : Q30_ONE - SB;
            localparam logic [63:0] C16 = (CS + 64'h8000) >> 16;
            localparam logic [63:0] S16 = (SN + 64'h8000) >> 16;
            localparam logic [15:0] CP = C16[15:0];
            localparam logic [15:0] SP = S16[15:0];
            localparam logic [15:0] CM = 16'd0 - CP;
            localparam logic [15:0] SM = 16'd0 - SP;
            localparam logic [15:0] OC = (QD == 0) ? CP : (QD == 1) ? SM : (QD == 2) ? CM : SP;
            localparam logic [15:0] OS = (QD == 0) ? SP : (QD == 1) ? CP : (QD == 2) ? SM : CM;
            assign rom_w[N][J] = {OS, OC};
         end
      end
   end

   logic [31:0] trig_ff [MAX_RING];

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RING; i++) begin
         trig_ff[i] <= rom_w[ring_size[RW-1:0]][i];
      end
   end

   bst_type     st_ff;
   xdst_type    xdst_ff;
   job_type     job_ff;
   unit_type    lat_ff [3];
   unit_type    bil_ff [3];
   unit_type    d_ff [3];
   unit_type    ca_ff [3];
   unit_type    cb_ff [3];
   logic signed [31:0] prod_ff [6];
   logic        deg_ff;
   logic        start_ff;
   wide_type    vec_ff [3];
   logic [JW-1:0] j_ff;
   unit_type    c_ff;
   unit_type    s_ff;
   logic signed [31:0] vp_ff [6];
   unit_type    nr_ff [3];
   logic signed [32:0] rp_ff [3];
   logic        out_valid_ff;
   coord_type   vx_ff [3];
   unit_type    nx_ff [3];
   logic [15:0] num_ff;
   logic [4:0]  around_ff;
   logic        last_ff;
   logic        odeg_ff;

   wide_type    t [3];
   logic        out_free;
   logic        ring_end;

   assign t[0] = 34'(prod_ff[0]) - 34'(prod_ff[1]);
   assign t[1] = 34'(prod_ff[2]) - 34'(prod_ff[3]);
   assign t[2] = 34'(prod_ff[4]) - 34'(prod_ff[5]);

   assign out_free = !out_valid_ff || rsp_ready;
   assign ring_end = (7'(j_ff) + 7'd1 == 7'(ring_size));
   assign pop      = (st_ff == B_IDLE) && !empty;

   assign unit_req.start  = start_ff;
   assign unit_req.vec[0] = vec_ff[0];
   assign unit_req.vec[1] = vec_ff[1];
   assign unit_req.vec[2] = vec_ff[2];

   assign rsp_valid        = out_valid_ff;
   assign rsp_vertex_x     = vx_ff[0];
   assign rsp_vertex_y     = vx_ff[1];
   assign rsp_vertex_z     = vx_ff[2];
   assign rsp_normal_x     = nx_ff[0];
   assign rsp_normal_y     = nx_ff[1];
   assign rsp_normal_z     = nx_ff[2];
   assign rsp_ring_number  = num_ff;
   assign rsp_around_index = around_ff;
   assign rsp_last_of_path = last_ff;
   assign rsp_degenerate   = odeg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         start_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // unitizer start pulses: new job, seed vector, carried cross product
         start_ff <= ((st_ff == B_IDLE) && !empty) || (st_ff == B_SEED) ||
                     ((st_ff == B_XSUB) && (xdst_ff == X_PRE));
         if (rsp_ready && !((st_ff == B_VOUT) && out_free)) out_valid_ff <= 1'b0;
         case (st_ff)
            B_IDLE: begin
               if (!empty) begin
                  job_ff <= pop_job;
                  deg_ff <= 1'b0;
                  if (pop_job.first) begin
                     lat_ff[0] <= '0;
                     lat_ff[1] <= UNIT_NEG_ONE;
                     lat_ff[2] <= '0;
                     bil_ff[0] <= UNIT_NEG_ONE;
                     bil_ff[1] <= '0;
                     bil_ff[2] <= '0;
                  end
                  for (int k = 0; k < 3; k++) vec_ff[k] <= 34'($signed(pop_job.dir[k]));
                  st_ff <= B_UD;
               end
            end
            B_UD: begin
               if (unit_rsp.done) begin
                  if (unit_rsp.zero) begin
                     deg_ff <= 1'b1;
                     j_ff   <= '0;
                     st_ff  <= B_RD;
                  end else begin
                     for (int k = 0; k < 3; k++) begin
                        d_ff[k]  <= unit_rsp.u[k];
                        ca_ff[k] <= lat_ff[k];
                        cb_ff[k] <= unit_rsp.u[k];
                     end
                     xdst_ff <= X_PRE;
                     st_ff   <= job_ff.first ? B_SEED : B_XMUL;
                  end
               end
            end
            B_SEED: begin
               // x axis seed, y axis when the direction lies along x
               if (d_ff[2] == '0 && d_ff[1] == '0) begin
                  vec_ff[0] <= 34'(d_ff[2]);
                  vec_ff[1] <= '0;
                  vec_ff[2] <= -34'(d_ff[0]);
               end else begin
                  vec_ff[0] <= '0;
                  vec_ff[1] <= -34'(d_ff[2]);
                  vec_ff[2] <= 34'(d_ff[1]);
               end
               st_ff <= B_UT;
            end
            B_XMUL: begin
               prod_ff[0] <= ca_ff[1] * cb_ff[2];
               prod_ff[1] <= ca_ff[2] * cb_ff[1];
               prod_ff[2] <= ca_ff[2] * cb_ff[0];
               prod_ff[3] <= ca_ff[0] * cb_ff[2];
               prod_ff[4] <= ca_ff[0] * cb_ff[1];
               prod_ff[5] <= ca_ff[1] * cb_ff[0];
               st_ff      <= B_XSUB;
            end
            B_XSUB: begin
               case (xdst_ff)
                  X_PRE: begin
                     for (int k = 0; k < 3; k++) vec_ff[k] <= t[k];
                     st_ff <= B_UT;
                  end
                  X_TO_BIL: begin
                     for (int k = 0; k < 3; k++) bil_ff[k] <= sat16(rnd14(40'(t[k])));
                     j_ff  <= '0;
                     st_ff <= B_RD;
                  end
                  default: begin
                     for (int k = 0; k < 3; k++) lat_ff[k] <= sat16(rnd14(40'(t[k])));
                     j_ff  <= '0;
                     st_ff <= B_RD;
                  end
               endcase
            end
            B_UT: begin
               if (unit_rsp.done) begin
                  if (unit_rsp.zero) begin
                     // lateral along the direction: keep the previous frame
                     j_ff  <= '0;
                     st_ff <= B_RD;
                  end else if (job_ff.first) begin
                     for (int k = 0; k < 3; k++) begin
                        lat_ff[k] <= unit_rsp.u[k];
                        ca_ff[k]  <= unit_rsp.u[k];
                        cb_ff[k]  <= d_ff[k];
                     end
                     xdst_ff <= X_TO_BIL;
                     st_ff   <= B_XMUL;
                  end else begin
                     for (int k = 0; k < 3; k++) begin
                        bil_ff[k] <= unit_rsp.u[k];
                        ca_ff[k]  <= d_ff[k];
                        cb_ff[k]  <= unit_rsp.u[k];
                     end
                     xdst_ff <= X_TO_LAT;
                     st_ff   <= B_XMUL;
                  end
               end
            end
            B_RD: begin
               c_ff  <= trig_ff[j_ff[IW-1:0]][15:0];
               s_ff  <= trig_ff[j_ff[IW-1:0]][31:16];
               st_ff <= B_VMUL;
            end
            B_VMUL: begin
               for (int k = 0; k < 3; k++) begin
                  vp_ff[k]     <= c_ff * lat_ff[k];
                  vp_ff[3 + k] <= s_ff * bil_ff[k];
               end
               st_ff <= B_VNR;
            end
            B_VNR: begin
               for (int k = 0; k < 3; k++) begin
                  nr_ff[k] <= sat16(rnd14(40'(vp_ff[k]) + 40'(vp_ff[3 + k])));
               end
               st_ff <= B_VRAD;
            end
            B_VRAD: begin
               for (int k = 0; k < 3; k++) rp_ff[k] <= nr_ff[k] * $signed({1'b0, radius});
               st_ff <= B_VOUT;
            end
            B_VOUT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  for (int k = 0; k < 3; k++) begin
                     vx_ff[k] <= sat24(40'($signed(job_ff.pt[k])) + rnd14(40'(rp_ff[k])));
                     nx_ff[k] <= nr_ff[k];
                  end
                  num_ff    <= job_ff.num;
                  around_ff <= 5'(j_ff);
                  last_ff   <= job_ff.final_ring && ring_end;
                  odeg_ff   <= deg_ff;
                  j_ff      <= j_ff + 1'b1;
                  st_ff     <= ring_end ? B_IDLE : B_RD;
               end
            end
            default: st_ff <= B_IDLE;
         endcase
      end
   end
endmodule

// File: design/tube_sweep_vertex_generator_top.sv
// top level of the tube sweep vertex generator: config registers and block wiring
//
// Path points come in one word at a time on req_*; every point but the first of a
// path yields one ring of ring_size vertex words on rsp_*, lagging by one point, and
// the final point flushes two rings (a path of one point gives nothing). Each ring
// needs frame work (cut short when the direction has zero length) and then vertex
// work: the frame sequencer runs the shared iterative unitizer twice per ring (once
// for a zero length direction; a normalize shift of up to 30 steps, a square root
// and three 17 step divisions), then each vertex goes through the table read,
// multiply, normal rounding, radius multiply and output steps of the multiply and
// saturate chain. A four entry job queue lets the point side keep taking words
// while rings are built, and the output register lets the next vertex be prepared
// while one waits. The trig table, registered from ring_size, needs no clearing pass.
// Config registers: radius at byte address 0, ring_size at 4 (clamped to 3..32).
module tube_sweep_vertex_generator_top #(
   parameter int MAX_RING = tsvg_pkg::MAX_RING_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // point words in
   input  logic                req_valid,
   output logic                req_ready,
   input  tsvg_pkg::coord_type req_point_x,
   input  tsvg_pkg::coord_type req_point_y,
   input  tsvg_pkg::coord_type req_point_z,
   input  logic                req_end_of_path,
   // vertex words out
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tsvg_pkg::coord_type rsp_vertex_x,
   output tsvg_pkg::coord_type rsp_vertex_y,
   output tsvg_pkg::coord_type rsp_vertex_z,
   output tsvg_pkg::unit_type  rsp_normal_x,
   output tsvg_pkg::unit_type  rsp_normal_y,
   output tsvg_pkg::unit_type  rsp_normal_z,
   output logic [15:0]         rsp_ring_number,
   output logic [4:0]          rsp_around_index,
   output logic                rsp_last_of_path,
   output logic                rsp_degenerate,
   // apb config port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import tsvg_pkg::*;

   // register indexes, taken from address bit 2
   localparam logic REG_RADIUS = 1'b0;
   localparam logic REG_RING   = 1'b1;

   localparam logic [5:0] RING_MAX   = 6'(MAX_RING);
   localparam logic [5:0] RING_RESET = (MAX_RING < 8) ? 6'(MAX_RING) : 6'd8;

   logic [15:0]  radius_ff;
   logic [5:0]   ring_ff;
   logic [5:0]   ring_wr;
   logic         wr_en;

   logic         q_push;
   job_type      q_push_job;
   logic         q_full;
   logic         q_pop;
   job_type      q_pop_job;
   logic         q_empty;
   unit_req_type unit_req;
   unit_rsp_type unit_rsp;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // clamp ring size into the supported range
   always_comb begin
      ring_wr = pwdata[5:0];
      if (ring_wr < 6'd3) ring_wr = 6'd3;
      if (ring_wr > RING_MAX) ring_wr = RING_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         ring_ff   <= RING_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            REG_RADIUS: radius_ff <= pwdata[15:0];
            REG_RING:   ring_ff   <= ring_wr;
            default:    radius_ff <= radius_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_RADIUS: prdata = {16'd0, radius_ff};
         REG_RING:   prdata = {26'd0, ring_ff};
         default:    prdata = '0;
      endcase
   end

   // front end: point window and job building
   tsvg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_end_of_path (req_end_of_path),
      .push            (q_push),
      .push_job        (q_push_job),
      .full            (q_full)
   );

   // ring jobs waiting for the back end
   tsvg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (q_pop_job),
      .empty    (q_empty)
   );

   // shared unitizer for direction and frame vectors
   tsvg_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   // frame transport and vertex emission
   tsvg_back #(
      .MAX_RING (MAX_RING)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .radius           (radius_ff),
      .ring_size        (ring_ff),
      .empty            (q_empty),
      .pop_job          (q_pop_job),
      .pop              (q_pop),
      .unit_req         (unit_req),
      .unit_rsp         (unit_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_vertex_z     (rsp_vertex_z),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_ring_number  (rsp_ring_number),
      .rsp_around_index (rsp_around_index),
      .rsp_last_of_path (rsp_last_of_path),
      .rsp_degenerate   (rsp_degenerate)
   );
endmodule

// File: bench/tube_sweep_vertex_generator_top_tb.sv
// self-checking testbench of the tube sweep vertex generator top level
`timescale 1ns / 1ps

module tube_sweep_vertex_generator_top_tb;
   import tsvg_pkg::*;

   localparam logic [2:0] ADDR_RADIUS    = 3'd0;
   localparam logic [2:0] ADDR_RING_SIZE = 3'd4;
   localparam int         MAX_RING       = 32;
   localparam int         SETTLE_CYCLES  = 400;   // longest ring build plus margin
   localparam int         CYCLE_LIMIT    = 4000000;
   localparam int         LONG_HOLD      = 3000;

   typedef longint vec3_type [3];

   // one vertex word as the block should send it
   typedef struct {
      coord_type   vx, vy, vz;
      unit_type    nx, ny, nz;
      logic [15:0] ring;
      logic [4:0]  around;
      logic        last;
      logic        degen;
   } vertex_word_type;

   // one row of the directed point list
   typedef struct {
      int x, y, z;
      bit eop;
   } point_row_type;

   logic        clock, reset;
   logic        req_valid, req_ready, req_end_of_path;
   coord_type   req_point_x, req_point_y, req_point_z;
   logic        rsp_valid, rsp_ready;
   coord_type   rsp_vertex_x, rsp_vertex_y, rsp_vertex_z;
   unit_type    rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [15:0] rsp_ring_number;
   logic [4:0]  rsp_around_index;
   logic        rsp_last_of_path, rsp_degenerate;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   tube_sweep_vertex_generator_top u_top (.*);

   // expected vertex words, oldest first
   vertex_word_type vertex_q [$];
   int              error_count;
   int              cycle_count;

   // sender burst shaping and receiver hold-off request
   int burst_left;
   bit sender_steady;
   bit long_hold_req;

   // ---------------------------------------------------------------------------
   // predictor state: mirror of the sweep, frame and trig table
   // ---------------------------------------------------------------------------
   longint      tube_radius;
   int          ring_len;
   vec3_type    prev_pt, cur_pt;
   longint      pts_in_path;
   int          held_pts;
   vec3_type    lat, bilat;
   longint      cos_tab [MAX_RING];
   longint      sin_tab [MAX_RING];

   function automatic longint round_shift(longint v, int sh);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clip(longint v, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // scale to a q2.14 unit vector, 0 when the vector is zero
   function automatic bit to_unit(input vec3_type v, output vec3_type u);
      longint unsigned len2, s, m, q;
      int k;
      len2 = 0;
      u = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
         m = (v[i] < 0) ? longint'(-v[i]) : v[i];
         len2 += m * m;
      end
      if (len2 == 0) return 0;
      k = 0;
      while (len2 < (64'd1 << 60)) begin
         len2 <<= 2;
         k++;
      end
      s = int_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
         m = (v[i] < 0) ? longint'(-v[i]) : v[i];
         q = ((m << k << 14) + s / 2) / s;
         u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic vec3_type cross3(vec3_type a, vec3_type b);
      vec3_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   // cosine and sine per around position, polynomial in the first quadrant
   function automatic void rebuild_trig();
      longint unsigned sk [6] = '{156, 110, 72, 42, 20, 6};
      longint unsigned ck [5] = '{132, 90, 56, 30, 12};
      longint unsigned a, q, r, x, x2, t, sn, cs, sub, n;
      longint c16, s16, oc, os;
      n = ring_len;
      for (longint unsigned j = 0; j < n; j++) begin
         a = (((j << 32) + n / 2) / n) & 64'hFFFF_FFFF;
         q = a >> 30;
         r = a & (Q30_ONE - 1);
         x = (r * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         t = Q30_ONE;
         for (int i = 0; i < 6; i++) t = Q30_ONE - ((x2 * t) >> 30) / sk[i];
         sn = (x * t) >> 30;
         t = Q30_ONE;
         for (int i = 0; i < 5; i++) t = Q30_ONE - ((x2 * t) >> 30) / ck[i];
         sub = ((x2 * t) >> 30) / 2;
         cs = (sub >= Q30_ONE) ? 0 : Q30_ONE - sub;
         c16 = (cs + 64'h8000) >> 16;
         s16 = (sn + 64'h8000) >> 16;
         case (q)
            0: begin oc = c16;  os = s16;  end
            1: begin oc = -s16; os = c16;  end
            2: begin oc = -c16; os = -s16; end
            default: begin oc = s16; os = -c16; end
         endcase
         cos_tab[j] = shortint'(oc);
         sin_tab[j] = shortint'(os);
      end
   endfunction

   function automatic void set_radius(longint unsigned value);
      tube_radius = value & 16'hFFFF;
   endfunction

   function automatic void set_ring_len(longint unsigned value);
      longint unsigned v;
      v = value & 6'h3F;
      if (v < 3) v = 3;
      if (v > MAX_RING) v = MAX_RING;
      ring_len = int'(v);
      rebuild_trig();
   endfunction

   // carry the frame to a new direction, returns 1 for a zero-length direction
   function automatic bit carry_frame(vec3_type dir, bit first);
      vec3_type d, t, u;
      if (first) begin
         lat   = '{0, -16384, 0};
         bilat = '{-16384, 0, 0};
      end
      if (!to_unit(dir, d)) return 1;
      if (first) begin
         t = '{0, -d[2], d[1]};
         if (t[1] == 0 && t[2] == 0) t = '{d[2], 0, -d[0]};
         if (!to_unit(t, u)) return 0;
         lat = u;
         t = cross3(lat, d);
         for (int i = 0; i < 3; i++) bilat[i] = clip(round_shift(t[i], 14), 16);
      end else begin
         t = cross3(lat, d);
         // lateral along the direction: keep the old frame
         if (!to_unit(t, u)) return 0;
         bilat = u;
         t = cross3(d, bilat);
         for (int i = 0; i < 3; i++) lat[i] = clip(round_shift(t[i], 14), 16);
      end
      return 0;
   endfunction

   function automatic void expect_ring(vec3_type pt, vec3_type dir, bit first, longint num,
                                       bit final_ring);
      vertex_word_type w;
      longint nr [3];
      longint v  [3];
      bit degen;
      degen = carry_frame(dir, first);
      for (int j = 0; j < ring_len; j++) begin
         for (int k = 0; k < 3; k++) begin
            nr[k] = clip(round_shift(cos_tab[j] * lat[k] + sin_tab[j] * bilat[k], 14), 16);
            v[k]  = clip(pt[k] + round_shift(nr[k] * tube_radius, 14), 24);
         end
         w.vx = v[0][23:0];  w.vy = v[1][23:0];  w.vz = v[2][23:0];
         w.nx = nr[0][15:0]; w.ny = nr[1][15:0]; w.nz = nr[2][15:0];
         w.ring   = num[15:0];
         w.around = j[4:0];
         w.last   = final_ring && (j + 1 == ring_len);
         w.degen  = degen;
         vertex_q.push_back(w);
      end
   endfunction

   // one accepted point word: queue the vertex words it releases
   function automatic void expect_point(coord_type px, coord_type py, coord_type pz,
                                        bit eop);
      vec3_type p, dir;
      p = '{px, py, pz};
      if (held_pts == 0) begin
         // first point of a path, dropped outright if it also ends the path
         cur_pt = p;
         pts_in_path = 1;
         held_pts = eop ? 0 : 1;
         if (eop) pts_in_path = 0;
         return;
      end
      for (int i = 0; i < 3; i++)
         dir[i] = p[i] - ((held_pts == 1) ? cur_pt[i] : prev_pt[i]);
      expect_ring(cur_pt, dir, held_pts == 1, (pts_in_path - 1) & 16'hFFFF, 0);
      if (eop) begin
         // final point flushes its own ring with a one-sided difference
         for (int i = 0; i < 3; i++) dir[i] = p[i] - cur_pt[i];
         expect_ring(p, dir, 0, pts_in_path & 16'hFFFF, 1);
         held_pts = 0;
         pts_in_path = 0;
      end else begin
         prev_pt = cur_pt;
         cur_pt = p;
         pts_in_path = (pts_in_path + 1) & 16'hFFFF;
         held_pts = 2;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // clock, cycle limit
   // ---------------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tube_sweep_vertex_generator_top_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // vertex word checker
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      vertex_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (vertex_q.size() == 0) begin
            report_mismatch("unexpected word, ring", rsp_ring_number, -1);
         end else begin
            w = vertex_q.pop_front();
            if (rsp_vertex_x !== w.vx) report_mismatch("vertex_x", rsp_vertex_x, w.vx);
            if (rsp_vertex_y !== w.vy) report_mismatch("vertex_y", rsp_vertex_y, w.vy);
            if (rsp_vertex_z !== w.vz) report_mismatch("vertex_z", rsp_vertex_z, w.vz);
            if (rsp_normal_x !== w.nx) report_mismatch("normal_x", rsp_normal_x, w.nx);
            if (rsp_normal_y !== w.ny) report_mismatch("normal_y", rsp_normal_y, w.ny);
            if (rsp_normal_z !== w.nz) report_mismatch("normal_z", rsp_normal_z, w.nz);
            if (rsp_ring_number !== w.ring)
               report_mismatch("ring_number", rsp_ring_number, w.ring);
            if (rsp_around_index !== w.around)
               report_mismatch("around_index", rsp_around_index, w.around);
            if (rsp_last_of_path !== w.last)
               report_mismatch("last_of_path", rsp_last_of_path, w.last);
            if (rsp_degenerate !== w.degen)
               report_mismatch("degenerate", rsp_degenerate, w.degen);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: own stall pattern, stretches of steady ready, one long hold-off
   // ---------------------------------------------------------------------------
   initial begin
      int stretch, style;
      rsp_ready = 0;
      stretch = 0;
      style = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            // hold off long enough for the job queue to fill and stall the input
            rsp_ready = 0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold_req = 0;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(200, 20);
               style = $urandom_range(3, 0);
            end
            stretch--;
            case (style)
               0: rsp_ready = 1;                              // always ready
               1: rsp_ready = ($urandom_range(3, 0) != 0);    // light stalls
               2: rsp_ready = ($urandom_range(3, 0) == 0);    // heavy stalls
               default: rsp_ready = (cycle_count % 7) < 3;   // periodic
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // sender and config port
   // ---------------------------------------------------------------------------
   task automatic send_point(int x, int y, int z, bit eop);
      int gap;
      if (!sender_steady && burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         gap = $urandom_range(8, 0);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid       = 1;
      req_point_x     = x[23:0];
      req_point_y     = y[23:0];
      req_point_z     = z[23:0];
      req_end_of_path = eop;
      do @(posedge clock); while (!req_ready);
      expect_point(req_point_x, req_point_y, req_point_z, eop);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      req_valid = 0;
      psel    = 1;
      penable = 0;
      pwrite  = 1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_RADIUS) set_radius(data);
      else set_ring_len(data);
      @(negedge clock);
      psel    = 0;
      penable = 0;
      pwrite  = 0;
   endtask

   // wait for every expected word, then for any ring still being built
   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int rand_coord();
      return int'({{8{1'b0}}, $urandom()} << 8) >>> 8;
   endfunction

   // random paths: mostly smooth walks, some repeats, jumps and one-point paths
   task automatic random_paths(int n_items);
      int sent, len, x, y, z, kind, span;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(9, 0);
         len = (kind == 0) ? 1 : (kind < 8) ? $urandom_range(6, 2) : $urandom_range(20, 7);
         span = ($urandom_range(1, 0) != 0) ? 512 : 32768;
         if ($urandom_range(2, 0) == 0) begin
            x = rand_coord(); y = rand_coord(); z = rand_coord();
         end else begin
            x = $urandom_range(4000, 0) - 2000;
            y = $urandom_range(4000, 0) - 2000;
            z = $urandom_range(4000, 0) - 2000;
         end
         for (int i = 0; i < len; i++) begin
            send_point(x, y, z, i == len - 1);
            sent++;
            case ($urandom_range(15, 0))
               0: ;                                              // repeated point
               1: begin x = rand_coord(); y = rand_coord(); z = rand_coord(); end
               default: begin
                  x = int'(clip(x + int'($urandom_range(span, 0)) - span / 2, 24));
                  y = int'(clip(y + int'($urandom_range(span, 0)) - span / 2, 24));
                  z = int'(clip(z + int'($urandom_range(span, 0)) - span / 2, 24));
               end
            endcase
         end
      end
   endtask

   // directed points, all checked by the predictor
   localparam int DIR_ROWS = 22;
   point_row_type directed [DIR_ROWS] = '{
      // one-point path at the positive extreme: dropped
      '{8388607, 8388607, 8388607, 1},
      // zero-length first direction, preset frame for +z
      '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 256, 1},
      // path along x: seed falls back to the y axis
      '{0, 0, 0, 0}, '{256, 0, 0, 0}, '{512, 0, 0, 1},
      // lateral ends up along the direction, old frame kept
      '{0, 0, 0, 0}, '{0, 0, 256, 0}, '{0, -256, 0, 0}, '{0, -512, 0, 1},
      // central difference of zero length mid path
      '{0, 0, 0, 0}, '{100, 50, 0, 0}, '{0, 0, 0, 0}, '{5, 5, 5, 1},
      // coordinate extremes, vertices saturate
      '{8388607, 8388607, 8388607, 0}, '{-8388608, -8388608, -8388608, 0},
      '{8388607, -8388608, 0, 0}, '{-8388608, 8388607, -1, 1},
      // minimal two-point path near the edge
      '{-8388608, 0, 8388607, 0}, '{-8388600, 3, 8388607, 1},
      // one-point path at the negative extreme
      '{-8388608, -8388608, -8388608, 1}
   };

   // config settings per phase: extremes of both registers, clamping, randoms
   localparam int PHASES = 7;
   int phase_radius [PHASES] = '{0, 65535, 1234, 300, 256, 4096, -1};
   int phase_ring   [PHASES] = '{3, 32, 0, 63, 5, 2, -1};
   int phase_items  [PHASES] = '{70, 25, 70, 20, 90, 80, 120};

   initial begin
      error_count   = 0;
      cycle_count   = 0;
      burst_left    = 0;
      sender_steady = 0;
      long_hold_req = 0;
      reset           = 1;
      req_valid       = 0;
      req_point_x     = '0;
      req_point_y     = '0;
      req_point_z     = '0;
      req_end_of_path = 0;
      psel    = 0;
      penable = 0;
      pwrite  = 0;
      paddr   = '0;
      pwdata  = '0;

      // predictor reset state
      tube_radius = 256;
      ring_len = 8;
      prev_pt = '{0, 0, 0};
      cur_pt  = '{0, 0, 0};
      lat     = '{0, 0, 0};
      bilat   = '{0, 0, 0};
      pts_in_path = 0;
      held_pts = 0;
      for (int i = 0; i < MAX_RING; i++) begin
         cos_tab[i] = 0;
         sin_tab[i] = 0;
      end
      rebuild_trig();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed part at reset settings
      foreach (directed[i])
         send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].eop);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         csr_write(ADDR_RADIUS, (phase_radius[ph] < 0) ? $urandom_range(65535, 0)
                                                       : phase_radius[ph]);
         csr_write(ADDR_RING_SIZE, (phase_ring[ph] < 0) ? $urandom_range(63, 0)
                                                        : phase_ring[ph]);
         sender_steady = (ph % 3 == 1);
         // one long receiver hold-off while points keep coming
         if (ph == 4) long_hold_req = 1;
         random_paths(phase_items[ph]);
         // sender pauses until every expected word is back
         drain();
      end

      if (error_count == 0) begin
         $display("tube_sweep_vertex_generator_top_tb: done, clean");
      end else begin
         $display("tube_sweep_vertex_generator_top_tb: done, errors");
      end
      $finish;
   end

endmodule

// File: tube_sweep_vertex_generator_top.f
design/tsvg_pkg.sv
design/tsvg_queue.sv
design/tsvg_front.sv
design/tsvg_unit.sv
design/tsvg_back.sv
design/tube_sweep_vertex_generator_top.sv
bench/tube_sweep_vertex_generator_top_tb.sv
